// File: rtl/core/dtf_pkg.sv
// constants, widths and the power-of-ten table for the decimal text converter
// no dependencies; imported by decimal_text_to_fixed_point and the testbench
`default_nettype none
package dtf_pkg;

	localparam int FRAC_DIGITS = 9;
	localparam int INT_BITS    = 16;
	localparam int FRAC_BITS   = 32;

	localparam int VALUE_W = INT_BITS + FRAC_BITS + 1;
	// fraction numerator stays below 10^FRAC_DIGITS
	localparam int NUM_W   = $clog2(10 ** FRAC_DIGITS);
	localparam int CNT_W   = $clog2(FRAC_DIGITS + 1);
	localparam int ITER_W  = $clog2(FRAC_BITS + 1);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;

	localparam logic [INT_BITS-1:0] INT_MAX = {INT_BITS{1'b1}};

	typedef logic [NUM_W-1:0] num_t;

	function automatic num_t pow10(input logic [CNT_W-1:0] k);
		logic [63:0] p;
		case (k)
			4'd0:    p = 64'd1;
			4'd1:    p = 64'd10;
			4'd2:    p = 64'd100;
			4'd3:    p = 64'd1000;
			4'd4:    p = 64'd10000;
			4'd5:    p = 64'd100000;
			4'd6:    p = 64'd1000000;
			4'd7:    p = 64'd10000000;
			4'd8:    p = 64'd100000000;
			4'd9:    p = 64'd1000000000;
			default: p = 64'd1;
		endcase
		return p[NUM_W-1:0];
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/decimal_text_to_fixed_point.sv
// decimal text to signed fixed-point converter, top level
// depends on dtf_pkg for widths, character codes and the power-of-ten table
//
// input channel: one ASCII character per transaction on char_code, taken when
// in_valid is high and in_stall is low. a NUL ends the string and yields one
// result transaction (value, invalid, saturated); other characters yield none.
// every non-NUL character is taken without a stall, so a string streams at one
// character per cycle. a NUL starts a restoring division of the fraction
// numerator by 10^k, one quotient bit per cycle through a single shared
// compare/subtract unit, FRAC_BITS (32) quotient bits in all; then the result
// is loaded into the output register and out_valid rises. in_stall is high
// from the NUL being taken until that load.
// the result sits in an output register; characters of the next string are
// taken while it waits. if out_stall holds the previous result when a new one
// is ready, the block waits with in_stall high until that result is taken.
// arst_n (asynchronous, active low) clears the parser to the start of a
// string and empties the output register.
`default_nettype none
module decimal_text_to_fixed_point (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_stall,
	input  wire  [7:0]                         char_code,
	output logic                               out_valid,
	input  wire                                out_stall,
	output logic signed [dtf_pkg::VALUE_W-1:0] value,
	output logic                               invalid,
	output logic                               saturated
);
	import dtf_pkg::*;

	localparam logic [2:0] PH_START = 3'd0;
	localparam logic [2:0] PH_INT   = 3'd1;
	localparam logic [2:0] PH_FRAC  = 3'd2;
	localparam logic [2:0] PH_TAIL  = 3'd3;
	localparam logic [2:0] PH_BAD   = 3'd4;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]           state_q;
	logic [2:0]           phase_q;
	logic                 neg_q;
	logic [INT_BITS-1:0]  acc_q;
	logic                 ovf_q;
	num_t                 num_q;      // fraction numerator, then division remainder
	logic [CNT_W-1:0]     cnt_q;
	num_t                 div_q;
	logic [FRAC_BITS-1:0] quo_q;
	logic [ITER_W-1:0]    iter_q;
	logic                 bad_q;

	logic                 is_digit;
	logic [3:0]           dval;
	logic [INT_BITS+3:0]  acc_next;
	logic [NUM_W+3:0]     num_next;
	logic [NUM_W:0]       rem_shift;
	logic [NUM_W:0]       rem_diff;
	logic                 rem_ge;
	logic [VALUE_W-1:0]   mag;
	logic                 take_in;
	logic                 out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign take_in  = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;

	always_comb begin
		is_digit = (char_code inside {[CH_0:CH_9]});
	end
	assign dval     = char_code[3:0];
	assign acc_next = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {{INT_BITS{1'b0}}, dval};
	assign num_next = {1'b0, num_q, 3'b000} + {3'b000, num_q, 1'b0} + {{NUM_W{1'b0}}, dval};

	// shared compare/subtract of the restoring divider
	assign rem_shift = {num_q, 1'b0};
	assign rem_diff  = rem_shift - {1'b0, div_q};
	assign rem_ge    = (rem_shift >= {1'b0, div_q});

	assign mag = {1'b0, acc_q, quo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= PH_START;
			neg_q     <= 1'b0;
			acc_q     <= '0;
			ovf_q     <= 1'b0;
			num_q     <= '0;
			cnt_q     <= '0;
			iter_q    <= '0;
			bad_q     <= 1'b0;
			out_valid <= 1'b0;
			invalid   <= 1'b0;
			saturated <= 1'b0;
		end else begin
			if (out_valid && !out_stall && state_q != ST_DONE) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (take_in) begin
						if (char_code == CH_NUL) begin
							div_q   <= pow10(cnt_q);
							quo_q   <= '0;
							bad_q   <= (phase_q == PH_BAD);
							iter_q  <= ITER_W'(FRAC_BITS);
							state_q <= ST_DIV;
						end else begin
							case (phase_q)
								PH_START, PH_INT: begin
									if (phase_q == PH_START && char_code == CH_MINUS) begin
										neg_q   <= 1'b1;
										phase_q <= PH_INT;
									end else if (char_code == CH_DOT) begin
										phase_q <= PH_FRAC;
									end else if (is_digit) begin
										if (acc_next > {4'b0000, INT_MAX}) begin
											acc_q <= INT_MAX;
											ovf_q <= 1'b1;
										end else begin
											acc_q <= acc_next[INT_BITS-1:0];
										end
										phase_q <= PH_INT;
									end else begin
										phase_q <= PH_BAD;
									end
								end
								PH_FRAC: begin
									if (is_digit) begin
										if (cnt_q < CNT_W'(FRAC_DIGITS)) begin
											num_q <= num_next[NUM_W-1:0];
											cnt_q <= cnt_q + CNT_W'(1);
										end
									end else begin
										phase_q <= PH_TAIL;
									end
								end
								default: begin
								end
							endcase
						end
					end
				end
				ST_DIV: begin
					if (rem_ge) begin
						num_q <= rem_diff[NUM_W-1:0];
					end else begin
						num_q <= rem_shift[NUM_W-1:0];
					end
					quo_q  <= {quo_q[FRAC_BITS-2:0], rem_ge};
					iter_q <= iter_q - ITER_W'(1);
					if (iter_q == ITER_W'(1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						if (bad_q) begin
							value     <= '0;
							saturated <= 1'b0;
						end else begin
							value     <= neg_q ? -$signed(mag) : $signed(mag);
							saturated <= ovf_q;
						end
						invalid   <= bad_q;
						out_valid <= 1'b1;
						// back to the start of a string
						phase_q   <= PH_START;
						neg_q     <= 1'b0;
						acc_q     <= '0;
						ovf_q     <= 1'b0;
						num_q     <= '0;
						cnt_q     <= '0;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: sim/testbench.sv
// self-checking testbench for decimal_text_to_fixed_point: directed and random strings
// depends on dtf_pkg and the rtl top level; a scoreboard class predicts every result
`default_nettype none
module testbench;
	import dtf_pkg::*;

	localparam int IDLE_LIMIT  = 2000;
	localparam int DRAIN_WAIT  = 3 * FRAC_BITS;
	localparam int TEXT_CHARS  = 1050;
	localparam int HOLD_CYCLES = 400;

	typedef enum logic [2:0] {
		SCAN_START,
		SCAN_INT,
		SCAN_FRAC,
		SCAN_TAIL,
		SCAN_BAD
	} scan_phase_t;

	typedef struct {
		logic signed [VALUE_W-1:0] value;
		logic                      invalid;
		logic                      saturated;
	} fixed_result_t;

	class dtf_scoreboard;
		fixed_result_t expected_q[$];
		int            errors;
		scan_phase_t   phase;
		bit            negative;
		logic [31:0]   whole;
		bit            clamped;
		logic [63:0]   numerator;
		int            digits;

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			phase     = SCAN_START;
			negative  = 1'b0;
			whole     = '0;
			clamped   = 1'b0;
			numerator = '0;
			digits    = 0;
		endfunction

		function void take_integer_char(logic [7:0] c);
			logic [31:0] next;
			if (c == CH_DOT) begin
				phase = SCAN_FRAC;
			end else if (c >= CH_0 && c <= CH_9) begin
				next = whole * 10 + (c - CH_0);
				if (next > INT_MAX) begin
					next    = INT_MAX;
					clamped = 1'b1;
				end
				whole = next;
				phase = SCAN_INT;
			end else begin
				phase = SCAN_BAD;
			end
		endfunction

		// called for every accepted character; a NUL queues the predicted number
		function void note_char(logic [7:0] c);
			logic [63:0]        scale;
			logic [63:0]        frac_part;
			logic [VALUE_W-1:0] mag;
			fixed_result_t      r;
			if (c == CH_NUL) begin
				r.value     = '0;
				r.invalid   = (phase == SCAN_BAD);
				r.saturated = 1'b0;
				if (!r.invalid) begin
					scale = 64'd1;
					for (int i = 0; i < digits; i++)
						scale = scale * 10;
					frac_part   = (numerator << FRAC_BITS) / scale;
					mag         = {1'b0, whole[INT_BITS-1:0], frac_part[FRAC_BITS-1:0]};
					r.value     = negative ? -mag : mag;
					r.saturated = clamped;
				end
				expected_q.push_back(r);
				clear();
			end else begin
				case (phase)
					SCAN_START: begin
						if (c == CH_MINUS) begin
							negative = 1'b1;
							phase    = SCAN_INT;
						end else begin
							take_integer_char(c);
						end
					end
					SCAN_INT: take_integer_char(c);
					SCAN_FRAC: begin
						if (c >= CH_0 && c <= CH_9) begin
							if (digits < FRAC_DIGITS) begin
								numerator = numerator * 10 + (c - CH_0);
								digits++;
							end
						end else begin
							phase = SCAN_TAIL;
						end
					end
					default: ;
				endcase
			end
		endfunction

		function void check_result(logic signed [VALUE_W-1:0] v, logic inv, logic sat);
			fixed_result_t r;
			if (expected_q.size() == 0) begin
				$error("result transaction with nothing expected: value %0d", v);
				errors++;
			end else begin
				r = expected_q.pop_front();
				if (r.value !== v) begin
					$error("value: expected %0d, got %0d", r.value, v);
					errors++;
				end
				if (r.invalid !== inv) begin
					$error("invalid: expected %0b, got %0b", r.invalid, inv);
					errors++;
				end
				if (r.saturated !== sat) begin
					$error("saturated: expected %0b, got %0b", r.saturated, sat);
					errors++;
				end
			end
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [7:0]                char_code = CH_NUL;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic signed [VALUE_W-1:0] value;
	logic                      invalid;
	logic                      saturated;

	dtf_scoreboard sb = new();
	logic [7:0]    text_q[$];
	int            chars_sent = 0;

	decimal_text_to_fixed_point u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_code (char_code),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value),
		.invalid   (invalid),
		.saturated (saturated)
	);

	always #1 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [7:0] rand_digit();
		return CH_0 + 8'($urandom_range(0, 9));
	endfunction

	// fills text_q with one random string and its terminating NUL
	function automatic void compose_string();
		int kind;
		int n;
		kind = $urandom_range(0, 9);
		if (kind <= 6) begin
			if ($urandom_range(0, 2) == 0)
				text_q.push_back(CH_MINUS);
			n = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 5) : $urandom_range(5, 8);
			repeat (n) text_q.push_back(rand_digit());
			if ($urandom_range(0, 3) != 0) begin
				text_q.push_back(CH_DOT);
				n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 12)
				                                : $urandom_range(0, 8);
				repeat (n) text_q.push_back(rand_digit());
				if ($urandom_range(0, 2) == 0)
					repeat ($urandom_range(1, 3))
						text_q.push_back(8'($urandom_range(1, 255)));
			end
		end else if (kind == 7) begin
			// integers around the clamp point
			if ($urandom_range(0, 1) == 0)
				text_q.push_back(CH_MINUS);
			text_q.push_back(CH_0 + 8'd6);
			text_q.push_back(CH_0 + 8'd5);
			text_q.push_back(CH_0 + 8'd5);
			text_q.push_back(CH_0 + 8'd3);
			text_q.push_back(rand_digit());
			if ($urandom_range(0, 1) == 0) begin
				text_q.push_back(CH_DOT);
				repeat ($urandom_range(1, 9)) text_q.push_back(rand_digit());
			end
		end else begin
			// noise: arbitrary bytes mixed with syntax characters
			repeat ($urandom_range(1, 8)) begin
				case ($urandom_range(0, 3))
					0: text_q.push_back(8'($urandom_range(1, 255)));
					1: text_q.push_back(CH_MINUS);
					2: text_q.push_back(CH_DOT);
					default: text_q.push_back(rand_digit());
				endcase
			end
		end
		text_q.push_back(CH_NUL);
	endfunction

	task automatic send_char(input logic [7:0] c, input bit steady);
		int n;
		in_valid  <= 1'b1;
		char_code <= c;
		do @(posedge clk); while (in_stall);
		sb.note_char(c);
		chars_sent++;
		n = steady ? 0 : gap_len();
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_text(input bit steady);
		while (text_q.size() != 0)
			send_char(text_q.pop_front(), steady);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty string, lone minus, lone period, clamped integer, bad characters,
		// all-ones byte, fraction ended by a second period, doubled minus
		text_q = '{CH_NUL,
		           CH_MINUS, CH_NUL,
		           CH_DOT, CH_NUL,
		           CH_0 + 8'd7, CH_0, CH_0, CH_0, CH_0, CH_NUL,
		           CH_MINUS, CH_0 + 8'd1, "a", CH_NUL,
		           8'hFF, CH_NUL,
		           CH_MINUS, CH_DOT, CH_0 + 8'd5, CH_DOT, 8'hFF, CH_NUL,
		           CH_MINUS, CH_MINUS, CH_NUL};
		send_text(1'b0);

		while (chars_sent < TEXT_CHARS) begin
			compose_string();
			send_text($urandom_range(0, 3) == 0);
		end
		in_valid <= 1'b0;

		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// result side: random stalls, free-running windows, one long hold-off
	initial begin
		int  hold;
		int  free_run;
		int  received;
		bit  held_long;
		hold      = 0;
		free_run  = 0;
		received  = 0;
		held_long = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				sb.check_result(value, invalid, saturated);
				received++;
			end
			if (!held_long && received == 15) begin
				held_long = 1'b1;
				hold      = HOLD_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				if (free_run > 0)
					free_run--;
				else if ($urandom_range(0, 4) == 0)
					free_run = $urandom_range(20, 80);
				else
					hold = gap_len();
			end
		end
	end

	// counts cycles with no transaction on either channel and stops the run as a mismatch at IDLE_LIMIT
	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle = 0;
			else
				idle++;
			if (idle >= IDLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

endmodule
`default_nettype wire
